// File: design/assert_macros.svh
// Assertion helpers shared by the scanner modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

// File: design/sss_pkg.sv
package sss_pkg;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_WRITE_SEG = 3'd1,
        OP_SET_LEN   = 3'd2,
        OP_SET_LED   = 3'd3,
        OP_CLEAR     = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0] operation;
        logic [1:0] display_index;
        logic [4:0] position;
        logic [7:0] value;
        logic [2:0] led_number;
    } in_item_t;

    typedef struct packed {
        logic [3:0] scan_slot;
        logic [7:0] port_a_segments;
        logic [7:0] port_b_segments;
        logic [7:0] select_low_port;
        logic [7:0] select_high_port;
        logic       led_common;
    } out_item_t;

    typedef struct packed {
        logic [3:0] scan_slot;
        logic       show_a;
        logic       show_b;
        logic [7:0] led_bits;
    } scan_info_t;

    localparam int unsigned ROWS   = 4;
    localparam int unsigned DIGITS = 4;

    localparam logic [3:0]  LED_SLOT     = 4'd4;
    localparam logic [3:0]  UPPER_BASE   = 4'd5;
    localparam logic [2:0]  LED_DIGIT    = 3'd4;
    localparam logic [15:0] PERIOD_RESET = 16'd500;

    localparam logic [7:0] LOWER_STROBE [DIGITS] = '{8'h10, 8'h20, 8'h40, 8'h80};
    localparam logic [7:0] UPPER_STROBE [DIGITS] = '{8'h01, 8'h02, 8'h04, 8'h08};

endpackage

// File: design/sss_store.sv
module sss_store #(
    parameter int MAX_CHARS = 32,
    parameter int ADDR_W    = $clog2(4 * MAX_CHARS)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [7:0]        rd_data_a,
    output logic [7:0]        rd_data_b
);

    logic [7:0] mem [4 * MAX_CHARS];
    logic [7:0] rd_a_reg;
    logic [7:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// File: design/sss_ctrl.sv
`include "assert_macros.svh"

module sss_ctrl #(
    parameter int MAX_CHARS = 32,
    parameter int ADDR_W    = $clog2(4 * MAX_CHARS)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_data,
    input  logic                item_we,
    input  sss_pkg::in_item_t   in_item,
    output logic                seg_we,
    output logic [ADDR_W-1:0]   seg_waddr,
    output logic [7:0]          seg_wdata,
    output logic                tick_we,
    output logic [ADDR_W-1:0]   rd_addr_a,
    output logic [ADDR_W-1:0]   rd_addr_b,
    output sss_pkg::scan_info_t scan_info
);
    import sss_pkg::*;

    localparam int LEN_W = $clog2(MAX_CHARS + 1);
    localparam int OFF_W = $clog2(MAX_CHARS + 4);
    localparam int IDX_W = $clog2(MAX_CHARS + 7);

    logic [15:0]      period_reg;
    logic [LEN_W-1:0] row_len_reg    [ROWS];
    logic [LEN_W-1:0] row_len_next   [ROWS];
    logic [OFF_W-1:0] offset_reg     [ROWS];
    logic [OFF_W-1:0] offset_next    [ROWS];
    logic [OFF_W-1:0] offset_tick    [ROWS];
    logic [16:0]      countdown_reg;
    logic [16:0]      countdown_next;
    logic [7:0]       leds_reg;
    logic [7:0]       leds_next;
    logic             upper_reg;
    logic             upper_next;
    logic [2:0]       digit_reg;
    logic [2:0]       digit_next;

    logic [16:0]      cd_dec;
    logic             expired;
    logic             any_long;
    logic [ROWS-1:0]  long_row;
    logic [OFF_W:0]   off_inc    [ROWS];
    logic [OFF_W:0]   off_limit  [ROWS];
    logic [LEN_W-1:0] len_sat;
    logic [1:0]       digit;
    logic [1:0]       row_a;
    logic [1:0]       row_b;
    logic [LEN_W-1:0] len_a;
    logic [LEN_W-1:0] len_b;
    logic [OFF_W-1:0] off_a;
    logic [OFF_W-1:0] off_b;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic             show_a;
    logic             show_b;
    logic [3:0]       slot;

    // scroll timer and offset stepping, as seen by a tick
    always_comb begin
        cd_dec   = (countdown_reg != '0) ? countdown_reg - 17'd1 : '0;
        expired  = (cd_dec == '0);
        any_long = 1'b0;
        for (int r = 0; r < ROWS; r++) begin
            long_row[r]  = (row_len_reg[r] > LEN_W'(DIGITS));
            any_long     = any_long | long_row[r];
            off_inc[r]   = {1'b0, offset_reg[r]} + (OFF_W+1)'(1);
            off_limit[r] = (OFF_W+1)'(row_len_reg[r]) + (OFF_W+1)'(DIGITS);
            if (expired && long_row[r]) begin
                offset_tick[r] = (off_inc[r] >= off_limit[r]) ? '0 : off_inc[r][OFF_W-1:0];
            end else begin
                offset_tick[r] = offset_reg[r];
            end
        end
    end

    // scan position and store read addresses
    always_comb begin
        digit = digit_reg[1:0];
        if (upper_reg) begin
            row_a = 2'd0;
            row_b = 2'd2;
            len_a = row_len_reg[0];
            len_b = row_len_reg[2];
            off_a = offset_tick[0];
            off_b = offset_tick[2];
            slot  = UPPER_BASE + {2'b00, digit};
        end else begin
            row_a = 2'd1;
            row_b = 2'd3;
            len_a = row_len_reg[1];
            len_b = row_len_reg[3];
            off_a = offset_tick[1];
            off_b = offset_tick[3];
            slot  = (digit_reg == LED_DIGIT) ? LED_SLOT : {2'b00, digit};
        end
        idx_a  = IDX_W'(off_a) + IDX_W'(digit);
        idx_b  = IDX_W'(off_b) + IDX_W'(digit);
        show_a = (idx_a < IDX_W'(len_a)) && (idx_a < IDX_W'(MAX_CHARS));
        show_b = (idx_b < IDX_W'(len_b)) && (idx_b < IDX_W'(MAX_CHARS));
        rd_addr_a = show_a ? ADDR_W'(row_a) * ADDR_W'(MAX_CHARS) + ADDR_W'(idx_a) : '0;
        rd_addr_b = show_b ? ADDR_W'(row_b) * ADDR_W'(MAX_CHARS) + ADDR_W'(idx_b) : '0;
        scan_info.scan_slot = slot;
        scan_info.show_a    = show_a;
        scan_info.show_b    = show_b;
        scan_info.led_bits  = leds_reg;
    end

    assign len_sat   = (in_item.value > MAX_CHARS) ? LEN_W'(MAX_CHARS)
                                                   : LEN_W'(in_item.value);
    assign seg_we    = item_we && (in_item.operation == OP_WRITE_SEG)
                       && (in_item.position < MAX_CHARS);
    assign seg_waddr = ADDR_W'(in_item.display_index) * ADDR_W'(MAX_CHARS)
                       + ADDR_W'(in_item.position);
    assign seg_wdata = in_item.value;
    assign tick_we   = item_we && (in_item.operation == OP_TICK);

    always_comb begin
        row_len_next   = row_len_reg;
        offset_next    = offset_reg;
        countdown_next = countdown_reg;
        leds_next      = leds_reg;
        upper_next     = upper_reg;
        digit_next     = digit_reg;
        if (item_we) begin
            unique case (in_item.operation)
                OP_TICK: begin
                    offset_next    = offset_tick;
                    countdown_next = (expired && any_long) ? {1'b0, period_reg} : cd_dec;
                    if (!upper_reg) begin
                        if (digit_reg == LED_DIGIT) begin
                            digit_next = '0;
                            upper_next = 1'b1;
                        end else begin
                            digit_next = digit_reg + 3'd1;
                        end
                    end else if (digit_reg[1:0] == 2'd3) begin
                        digit_next = '0;
                        upper_next = 1'b0;
                    end else begin
                        digit_next = {1'b0, digit_reg[1:0]} + 3'd1;
                    end
                end
                OP_SET_LEN: begin
                    row_len_next[in_item.display_index] = len_sat;
                    if (len_sat > LEN_W'(DIGITS)) begin
                        for (int r = 0; r < ROWS; r++) begin
                            offset_next[r] = '0;
                        end
                        countdown_next = {period_reg, 1'b0};
                    end
                end
                OP_SET_LED: begin
                    leds_next[in_item.led_number] = in_item.value[0];
                end
                OP_CLEAR: begin
                    for (int r = 0; r < ROWS; r++) begin
                        row_len_next[r] = '0;
                        offset_next[r]  = '0;
                    end
                    countdown_next = {period_reg, 1'b0};
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg    <= PERIOD_RESET;
            countdown_reg <= '0;
            leds_reg      <= '0;
            upper_reg     <= 1'b0;
            digit_reg     <= '0;
            for (int r = 0; r < ROWS; r++) begin
                row_len_reg[r] <= '0;
                offset_reg[r]  <= '0;
            end
        end else begin
            if (cfg_we) begin
                period_reg <= cfg_data;
            end
            countdown_reg <= countdown_next;
            leds_reg      <= leds_next;
            upper_reg     <= upper_next;
            digit_reg     <= digit_next;
            row_len_reg   <= row_len_next;
            offset_reg    <= offset_next;
        end
    end

    `ASSERT_ALWAYS(a_digit_range, aclk, aresetn, (digit_reg <= LED_DIGIT) && !(upper_reg && (digit_reg == LED_DIGIT)), "scan digit counter out of range")

endmodule

// File: design/sss_out.sv
`include "assert_macros.svh"

module sss_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  sss_pkg::scan_info_t info,
    input  logic [7:0]          rd_data_a,
    input  logic [7:0]          rd_data_b,
    output logic                in_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output sss_pkg::out_item_t  m_item
);
    import sss_pkg::*;

    logic       stage_valid_reg;
    logic       stage_valid_next;
    scan_info_t info_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_reg;
    out_item_t  out_next;
    logic       out_take;
    logic       is_led;
    logic       is_upper;
    logic [3:0] upper_idx;

    // stage one holds the registered store read; the result register may stall
    assign out_take = !out_valid_reg || m_ready;
    assign in_ready = !stage_valid_reg || out_take;

    always_comb begin
        is_led    = (info_reg.scan_slot == LED_SLOT);
        is_upper  = (info_reg.scan_slot > LED_SLOT);
        upper_idx = info_reg.scan_slot - UPPER_BASE;

        out_next.scan_slot       = info_reg.scan_slot;
        out_next.port_a_segments = (!is_led && info_reg.show_a) ? rd_data_a : 8'h00;
        out_next.port_b_segments = is_led ? info_reg.led_bits
                                 : (info_reg.show_b ? rd_data_b : 8'h00);
        if (is_upper) begin
            out_next.select_low_port  = UPPER_STROBE[upper_idx[1:0]];
            out_next.select_high_port = 8'h00;
        end else if (is_led) begin
            out_next.select_low_port  = 8'h00;
            out_next.select_high_port = 8'h00;
        end else if (info_reg.scan_slot[1]) begin
            out_next.select_low_port  = 8'h00;
            out_next.select_high_port = LOWER_STROBE[info_reg.scan_slot[1:0]];
        end else begin
            out_next.select_low_port  = LOWER_STROBE[info_reg.scan_slot[1:0]];
            out_next.select_high_port = 8'h00;
        end
        out_next.led_common = is_upper;

        stage_valid_next = load ? 1'b1 : (out_take ? 1'b0 : stage_valid_reg);
        out_valid_next   = out_take ? stage_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            info_reg <= info;
        end
        if (out_take && stage_valid_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    `ASSERT_NEXT(a_load_fills_stage, aclk, aresetn, load, stage_valid_reg, "tick request lost in stage one")
    `ASSERT_ALWAYS(a_no_overrun, aclk, aresetn, !(load && stage_valid_reg && !out_take), "stage one overwritten while stalled")
    `ASSERT_ALWAYS(a_strobe_slot, aclk, aresetn, !out_valid_reg || ((out_reg.scan_slot == LED_SLOT) == ({out_reg.select_low_port, out_reg.select_high_port} == 16'h0000)), "digit strobe does not match slot")

endmodule

// File: design/scrolling_seven_segment_scanner.sv
// A tick result passes stage one, then the result register, before it shows on m_valid.
// One request per cycle unless m_ready stalls; store reads have one registered read stage.
// Write, length, led and clear requests take effect at acceptance and give no result.
// Reset (aresetn low, synchronous): lengths, offsets, timer, leds and scan position clear,
// scroll_period returns to 500; the segment store is not cleared.
module scrolling_seven_segment_scanner #(
    parameter int MAX_CHARS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  sss_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output sss_pkg::out_item_t m_item
);
    import sss_pkg::*;

    localparam int ADDR_W = $clog2(4 * MAX_CHARS);

    logic              accept;
    logic              seg_we;
    logic [ADDR_W-1:0] seg_waddr;
    logic [7:0]        seg_wdata;
    logic              tick_we;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic [7:0]        rd_data_a;
    logic [7:0]        rd_data_b;
    scan_info_t        scan_info;

    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    sss_ctrl #(
        .MAX_CHARS (MAX_CHARS),
        .ADDR_W    (ADDR_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .item_we   (accept),
        .in_item   (s_item),
        .seg_we    (seg_we),
        .seg_waddr (seg_waddr),
        .seg_wdata (seg_wdata),
        .tick_we   (tick_we),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .scan_info (scan_info)
    );

    sss_store #(
        .MAX_CHARS (MAX_CHARS),
        .ADDR_W    (ADDR_W)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (seg_we),
        .wr_addr   (seg_waddr),
        .wr_data   (seg_wdata),
        .rd_en     (tick_we),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    sss_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (tick_we),
        .info      (scan_info),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .in_ready  (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

// File: tb/scrolling_seven_segment_scanner_tb.sv
`timescale 1ns / 100ps

module scrolling_seven_segment_scanner_tb;
    import sss_pkg::*;

    localparam int MAX_CHARS = 32;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 150;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_item = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_item;

    scrolling_seven_segment_scanner #(
        .MAX_CHARS (MAX_CHARS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // scanner model state
    logic [7:0]  seg_mem [ROWS*MAX_CHARS];
    logic [5:0]  disp_len [ROWS];
    logic [5:0]  disp_off [ROWS];
    logic [16:0] scroll_cnt;
    logic [7:0]  led_state;
    logic        upper_ph;
    logic [2:0]  digit_cnt;
    logic [15:0] period_cfg;

    in_item_t  pending_requests [$];
    out_item_t expected_scans [$];

    int  slot_errors = 0;
    int  stuck_cycles = 0;
    int  send_gap = 0;
    int  ready_hold = 0;
    bit  steady = 1'b0;
    logic s_taken = 1'b0;

    task automatic scan_reset();
        for (int i = 0; i < ROWS*MAX_CHARS; i++) seg_mem[i] = '0;
        for (int r = 0; r < ROWS; r++) begin
            disp_len[r] = '0;
            disp_off[r] = '0;
        end
        scroll_cnt = '0;
        led_state  = '0;
        upper_ph   = 1'b0;
        digit_cnt  = '0;
        period_cfg = PERIOD_RESET;
    endtask

    task automatic restart_scroll();
        for (int r = 0; r < ROWS; r++) disp_off[r] = '0;
        scroll_cnt = {period_cfg, 1'b0};
    endtask

    function automatic logic [7:0] shown_seg(int row, int digit);
        int idx;
        idx = disp_off[row] + digit;
        if (idx < disp_len[row] && idx < MAX_CHARS) return seg_mem[row*MAX_CHARS + idx];
        return 8'h00;
    endfunction

    task automatic scan_predict(input in_item_t it);
        out_item_t res;
        bit        any_long;
        int        d;
        res = '0;
        case (it.operation)
            OP_WRITE_SEG: begin
                if (it.position < MAX_CHARS)
                    seg_mem[it.display_index*MAX_CHARS + it.position] = it.value;
            end
            OP_SET_LEN: begin
                disp_len[it.display_index] = (it.value > MAX_CHARS) ? 6'(MAX_CHARS)
                                                                     : it.value[5:0];
                if (disp_len[it.display_index] > DIGITS) restart_scroll();
            end
            OP_SET_LED: begin
                led_state[it.led_number] = it.value[0];
            end
            OP_CLEAR: begin
                for (int r = 0; r < ROWS; r++) disp_len[r] = '0;
                restart_scroll();
            end
            OP_TICK: begin
                if (scroll_cnt != 0) scroll_cnt = scroll_cnt - 1'b1;
                if (scroll_cnt == 0) begin
                    any_long = 1'b0;
                    for (int r = 0; r < ROWS; r++) begin
                        if (disp_len[r] > DIGITS) begin
                            disp_off[r] = disp_off[r] + 1'b1;
                            if (disp_off[r] >= disp_len[r] + DIGITS) disp_off[r] = '0;
                            any_long = 1'b1;
                        end
                    end
                    if (any_long) scroll_cnt = {1'b0, period_cfg};
                end
                d = digit_cnt;
                if (!upper_ph) begin
                    if (d < DIGITS) begin
                        res.scan_slot       = 4'(d);
                        res.port_a_segments = shown_seg(1, d);
                        res.port_b_segments = shown_seg(3, d);
                        if (d < 2) res.select_low_port = LOWER_STROBE[d];
                        else res.select_high_port = LOWER_STROBE[d];
                        digit_cnt = 3'(d + 1);
                    end else begin
                        res.scan_slot       = LED_SLOT;
                        res.port_b_segments = led_state;
                        digit_cnt = '0;
                        upper_ph  = 1'b1;
                    end
                end else begin
                    d = d % DIGITS;
                    res.scan_slot       = UPPER_BASE + 4'(d);
                    res.port_a_segments = shown_seg(0, d);
                    res.port_b_segments = shown_seg(2, d);
                    res.select_low_port = UPPER_STROBE[d];
                    res.led_common      = 1'b1;
                    if (d + 1 >= DIGITS) begin
                        digit_cnt = '0;
                        upper_ph  = 1'b0;
                    end else begin
                        digit_cnt = 3'(d + 1);
                    end
                end
                expected_scans.push_back(res);
            end
            default: ;
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic in_item_t mk(logic [2:0] op, logic [1:0] row, logic [4:0] pos,
                                    logic [7:0] val, logic [2:0] led);
        in_item_t it;
        it.operation     = op;
        it.display_index = row;
        it.position      = pos;
        it.value         = val;
        it.led_number    = led;
        return it;
    endfunction

    function automatic in_item_t gen_request();
        in_item_t it;
        int r;
        it = in_item_t'($urandom);
        r = $urandom_range(0, 99);
        if (r < 52) it.operation = OP_TICK;
        else if (r < 67) it.operation = OP_WRITE_SEG;
        else if (r < 79) begin
            it.operation = OP_SET_LEN;
            if ($urandom_range(0, 9) < 7) it.value = 8'($urandom_range(0, 12));
        end
        else if (r < 89) it.operation = OP_SET_LED;
        else if (r < 92) it.operation = OP_CLEAR;
        else it.operation = 3'($urandom_range(5, 7));
        return it;
    endfunction

    task automatic write_period(input logic [15:0] p);
        @(negedge aclk);
        cfg_data  <= p;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        period_cfg = p;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (pending_requests.size() != 0 || s_valid || expected_scans.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // driver
    always @(negedge aclk) begin
        if (!(s_valid && !s_taken)) begin
            if (send_gap > 0) begin
                s_valid <= 1'b0;
                send_gap--;
            end else if (pending_requests.size() != 0) begin
                s_item  <= pending_requests.pop_front();
                s_valid <= 1'b1;
                send_gap = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_ready <= 1'b0;
            ready_hold--;
        end else begin
            m_ready <= 1'b1;
            ready_hold = pick_gap();
        end
    end

    // monitor, predictor and watchdog
    always @(posedge aclk) begin
        out_item_t want;
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (expected_scans.size() == 0) begin
                slot_errors++;
                if (slot_errors <= 10)
                    $display("unexpected scan result: slot %0d a %h b %h sl %h sh %h com %b",
                             m_item.scan_slot, m_item.port_a_segments, m_item.port_b_segments,
                             m_item.select_low_port, m_item.select_high_port,
                             m_item.led_common);
            end else begin
                want = expected_scans.pop_front();
                if (m_item.scan_slot !== want.scan_slot
                        || m_item.port_a_segments !== want.port_a_segments
                        || m_item.port_b_segments !== want.port_b_segments
                        || m_item.select_low_port !== want.select_low_port
                        || m_item.select_high_port !== want.select_high_port
                        || m_item.led_common !== want.led_common) begin
                    slot_errors++;
                    if (slot_errors <= 10)
                        $display({"scan mismatch: expected slot %0d a %h b %h sl %h sh %h com %b,",
                                  " got slot %0d a %h b %h sl %h sh %h com %b"},
                                 want.scan_slot, want.port_a_segments, want.port_b_segments,
                                 want.select_low_port, want.select_high_port, want.led_common,
                                 m_item.scan_slot, m_item.port_a_segments,
                                 m_item.port_b_segments, m_item.select_low_port,
                                 m_item.select_high_port, m_item.led_common);
                end
            end
        end
        if (aresetn && s_valid && s_ready) scan_predict(s_item);
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("[scrolling_seven_segment_scanner] ERROR");
            $finish;
        end
    end

    initial begin
        logic [15:0] periods [PHASES];
        periods = '{16'd1, 16'd0, 16'd65535, 16'd2, 16'd3, 16'd5, 16'd8, 16'd12};
        scan_reset();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // fill the whole store so no tick ever shows an unwritten character
        for (int r = 0; r < ROWS; r++)
            for (int p = 0; p < MAX_CHARS; p++)
                pending_requests.push_back(mk(OP_WRITE_SEG, 2'(r), 5'(p),
                                              8'($urandom_range(0, 255)), 3'($urandom)));

        pending_requests.push_back(mk(OP_TICK, 2'd0, 5'd0, 8'h00, 3'd0));
        pending_requests.push_back(mk(OP_SET_LED, 2'd3, 5'd31, 8'h01, 3'd0));
        pending_requests.push_back(mk(OP_SET_LED, 2'd0, 5'd0, 8'hFF, 3'd7));
        pending_requests.push_back(mk(OP_SET_LED, 2'd1, 5'd7, 8'hFE, 3'd3));
        pending_requests.push_back(mk(OP_SET_LEN, 2'd0, 5'd0, 8'd4, 3'd0));
        pending_requests.push_back(mk(OP_SET_LEN, 2'd1, 5'd31, 8'd255, 3'd7));
        pending_requests.push_back(mk(OP_SET_LEN, 2'd2, 5'd0, 8'd5, 3'd0));
        pending_requests.push_back(mk(OP_SET_LEN, 2'd3, 5'd0, 8'd0, 3'd0));
        pending_requests.push_back(mk(3'd5, 2'd3, 5'd31, 8'hFF, 3'd7));
        pending_requests.push_back(mk(3'd6, 2'd1, 5'd10, 8'h5A, 3'd2));
        pending_requests.push_back(mk(3'd7, 2'd2, 5'd21, 8'hA5, 3'd5));
        for (int i = 0; i < 9; i++)
            pending_requests.push_back(mk(OP_TICK, 2'($urandom), 5'($urandom), 8'($urandom),
                                          3'($urandom)));
        pending_requests.push_back(mk(OP_CLEAR, 2'd0, 5'd0, 8'h00, 3'd0));
        pending_requests.push_back(mk(OP_SET_LEN, 2'd1, 5'd0, 8'd33, 3'd0));
        pending_requests.push_back(mk(OP_TICK, 2'd3, 5'd31, 8'hFF, 3'd7));
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            write_period(periods[ph]);
            steady = (ph == 3) || ($urandom_range(0, 4) == 0);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) pending_requests.push_back(gen_request());
            drain();
        end

        repeat (6) @(posedge aclk);
        if (slot_errors == 0 && expected_scans.size() == 0)
            $display("[scrolling_seven_segment_scanner] OK");
        else
            $display("[scrolling_seven_segment_scanner] ERROR");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/sss_pkg.sv
design/sss_store.sv
design/sss_ctrl.sv
design/sss_out.sv
design/scrolling_seven_segment_scanner.sv
tb/scrolling_seven_segment_scanner_tb.sv
